[rtl/core/assert_macros.svh]
// assertion helpers, empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// concurrent property checked on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[rtl/core/mei_lcc_pkg.sv]
`default_nettype none

package mei_lcc_pkg;

  localparam int unsigned ADDR_WIDTH = 32;
  localparam int unsigned TAG_WIDTH  = 8;
  localparam int unsigned OPCODE_W   = 4;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam int unsigned IN_BITS     = OPCODE_W + ADDR_WIDTH + TAG_WIDTH;
  localparam int unsigned IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = 1 + 2 + 1 + 1 + 2 + ADDR_WIDTH + TAG_WIDTH
                                        + ID_W + ID_W + 3 + 1;
  localparam int unsigned OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_ID = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_I  = 3'd0,
    ST_E  = 3'd1,
    ST_M  = 3'd2,
    ST_IE = 3'd3,
    ST_IM = 3'd4,
    ST_MI = 3'd5
  } line_state_e;

  typedef enum logic [OPCODE_W-1:0] {
    OP_GETIS = 4'd0,
    OP_GETIM = 4'd1,
    OP_GETSM = 4'd2,
    OP_GETOM = 4'd3,
    OP_PUTE  = 4'd4,
    OP_PUTM  = 4'd5,
    OP_REPL  = 4'd6,
    OP_DATAE = 4'd7,
    OP_DATAM = 4'd8,
    OP_WBACK = 4'd9,
    OP_DIRTY = 4'd10
  } opcode_e;

  typedef enum logic [1:0] {
    SEND_GETIS = 2'd0,
    SEND_GETIM = 2'd1,
    SEND_PUTM  = 2'd2
  } send_kind_e;

  typedef enum logic [1:0] {
    GRANT_NONE = 2'd0,
    GRANT_E    = 2'd1,
    GRANT_M    = 2'd2
  } grant_e;

  // decision for one message, decoder to top
  typedef struct packed {
    logic        hit;
    grant_e      grant;
    logic        err;
    logic        send;
    send_kind_e  kind;
    logic        wb;
    line_state_e next_state;
  } line_dec_t;

  // input item, last declared field (opcode) in the lowest bits
  typedef struct packed {
    logic [TAG_WIDTH-1:0]  request_tag;
    logic [ADDR_WIDTH-1:0] line_address;
    logic [OPCODE_W-1:0]   opcode;
  } in_item_t;

  // result item, last declared field (hit) in the lowest bits
  typedef struct packed {
    logic                  writeback;
    logic [2:0]            line_state_now;
    logic [ID_W-1:0]       send_dest;
    logic [ID_W-1:0]       send_source;
    logic [TAG_WIDTH-1:0]  send_tag;
    logic [ADDR_WIDTH-1:0] send_address;
    logic [1:0]            send_kind;
    logic                  send_valid;
    logic                  protocol_error;
    logic [1:0]            grant_kind;
    logic                  hit;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/mei_lcc_decode.sv]
`default_nettype none

module mei_lcc_decode (
  input  mei_lcc_pkg::line_state_e               state_i,
  input  logic [mei_lcc_pkg::OPCODE_W-1:0]       op_i,
  output mei_lcc_pkg::line_dec_t                 dec_o
);
  import mei_lcc_pkg::*;

  logic excl;
  logic perm;

  assign excl = (state_i == ST_E) || (state_i == ST_M);

  always_comb begin
    case (op_i) inside
      OP_GETIS, OP_PUTE, OP_PUTM:  perm = excl;
      OP_GETIM, OP_GETSM, OP_GETOM: perm = (state_i == ST_M);
      default:                      perm = 1'b0;
    endcase
  end

  always_comb begin
    dec_o            = '0;
    dec_o.grant      = GRANT_NONE;
    dec_o.kind       = SEND_GETIS;
    dec_o.next_state = state_i;
    if (perm) begin
      dec_o.hit   = 1'b1;
      dec_o.grant = (state_i == ST_M) ? GRANT_M : GRANT_E;
    end else begin
      unique case (state_i)
        ST_I: begin
          // a stale shared-to-modified request is handled as GETIM
          if (op_i == OP_GETIS) begin
            dec_o.send       = 1'b1;
            dec_o.kind       = SEND_GETIS;
            dec_o.next_state = ST_IE;
          end else if (op_i == OP_GETIM || op_i == OP_GETSM) begin
            dec_o.send       = 1'b1;
            dec_o.kind       = SEND_GETIM;
            dec_o.next_state = ST_IM;
          end else begin
            dec_o.err = 1'b1;
          end
        end
        ST_E: begin
          if (op_i == OP_GETIM || op_i == OP_GETSM || op_i == OP_GETOM ||
              op_i == OP_DIRTY) begin
            dec_o.next_state = ST_M;
          end else if (op_i == OP_REPL) begin
            dec_o.next_state = ST_I;
          end else begin
            dec_o.err = 1'b1;
          end
        end
        ST_M: begin
          if (op_i == OP_REPL) begin
            dec_o.send       = 1'b1;
            dec_o.kind       = SEND_PUTM;
            dec_o.wb         = 1'b1;
            dec_o.next_state = ST_MI;
          end else if (op_i != OP_DIRTY) begin
            dec_o.err = 1'b1;
          end
        end
        ST_IE: begin
          if (op_i == OP_DATAE) dec_o.next_state = ST_E;
          else dec_o.err = 1'b1;
        end
        ST_IM: begin
          if (op_i == OP_DATAM) dec_o.next_state = ST_M;
          else dec_o.err = 1'b1;
        end
        ST_MI: begin
          if (op_i == OP_WBACK) dec_o.next_state = ST_I;
          else dec_o.err = 1'b1;
        end
        default: begin
          dec_o.err = 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/mei_line_coherence_controller.sv]
// channel  | dir | handshake               | payload
// s_axis   | in  | s_axis_tvalid/tready    | opcode, line_address, request_tag
// m_axis   | out | m_axis_tvalid/tready    | hit ... writeback (one result per message)
// cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i (0 own id, 1 directory id)
//
// one message per cycle unless m_axis_tready low stalls it; input register then result register
// the line state register updates as a message moves into the result register
// reset clears the line state to I, both ids to zero and all valid flags
// a result held by m_axis_tready low still lets one more message enter the input
// register; the configuration port is always ready
`default_nettype none

`include "assert_macros.svh"

module mei_line_coherence_controller (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // opcode[3:0], line_address[35:4], request_tag[43:36], zero fill
  input  logic [mei_lcc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // hit[0], grant_kind[2:1], protocol_error[3], send_valid[4], send_kind[6:5],
  // send_address[38:7], send_tag[46:39], send_source[54:47], send_dest[62:55],
  // line_state_now[65:63], writeback[66], zero fill
  output logic [mei_lcc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mei_lcc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mei_lcc_pkg::ID_W-1:0]           cfg_data_i
);
  import mei_lcc_pkg::*;

  logic        s1_valid_q;
  in_item_t    s1_item_q;
  logic        out_valid_q;
  out_item_t   out_q;
  out_item_t   res_d;
  line_state_e line_state_q;
  line_dec_t   dec;
  logic [ID_W-1:0] own_id_q;
  logic [ID_W-1:0] dir_id_q;
  logic        out_ready;
  logic        s1_move;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_move       = s1_valid_q && out_ready;
  assign s_axis_tready = !s1_valid_q || out_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_q);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
      dir_id_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_OWN_ID) own_id_q <= cfg_data_i;
      if (cfg_index_i == CFG_DIR_ID) dir_id_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      line_state_q <= ST_I;
    end else begin
      if (s_axis_tready) s1_valid_q <= s_axis_tvalid;
      if (out_ready) out_valid_q <= s1_valid_q;
      if (s1_move) line_state_q <= dec.next_state;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) s1_item_q <= in_item_t'(s_axis_tdata[IN_BITS-1:0]);
    if (s1_move) out_q <= res_d;
  end

  mei_lcc_decode u_decode (
    .state_i (line_state_q),
    .op_i    (s1_item_q.opcode),
    .dec_o   (dec)
  );

  // message fields read as zero when nothing is sent
  always_comb begin
    res_d                = '0;
    res_d.hit            = dec.hit;
    res_d.grant_kind     = dec.grant;
    res_d.protocol_error = dec.err;
    res_d.send_valid     = dec.send;
    res_d.line_state_now = dec.next_state;
    res_d.writeback      = dec.wb;
    if (dec.send) begin
      res_d.send_kind    = dec.kind;
      res_d.send_address = s1_item_q.line_address;
      res_d.send_tag     = s1_item_q.request_tag;
      res_d.send_source  = own_id_q;
      res_d.send_dest    = dir_id_q;
    end
  end

  `ASSERT_NEVER(a_hit_exclusive, clk_i, rst_ni,
                out_valid_q && out_q.hit && (out_q.send_valid || out_q.protocol_error))
  `ASSERT_PROP(a_grant_on_hit, clk_i, rst_ni,
               out_valid_q |-> (out_q.hit == (out_q.grant_kind != GRANT_NONE)))
  `ASSERT_PROP(a_state_holds, clk_i, rst_ni,
               !s1_move |=> $stable(line_state_q))
  `ASSERT_PROP(a_err_keeps_state, clk_i, rst_ni,
               (s1_move && dec.err) |=> (line_state_q == $past(line_state_q)))
  `ASSERT_PROP(a_writeback_putm, clk_i, rst_ni,
               (out_valid_q && out_q.writeback) |->
               (out_q.send_valid && out_q.send_kind == SEND_PUTM &&
                out_q.line_state_now == ST_MI))

endmodule

`default_nettype wire
